// ===== hdl/dkv_pkg.sv =====
package dkv_pkg;

    // Character codes the parser looks for
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Default depth of the queue between parser and serializer
    localparam int QUEUE_DEPTH_DEF = 4;

    // Most output bytes that one input byte can produce
    localparam int MAX_RES = 3;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SEEK     = 3'd0,
        PH_KEY      = 3'd1,
        PH_PREVAL   = 3'd2,
        PH_VALSTART = 3'd3,
        PH_VALUE    = 3'd4,
        PH_IGNORE   = 3'd5
    } phase_t;

    // Parser state
    typedef struct packed {
        phase_t phase;
        logic   quoted_value;
        logic   quote_pending;
    } pstate_t;

    // One output byte with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       counted;
        logic       last;
    } res_t;

    // All output bytes that one input byte produces, slot 0 goes out first
    typedef struct packed {
        logic [1:0]         n;
        res_t [MAX_RES-1:0] slot;
    } entry_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== hdl/dash_keyword_value_tokenizer.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] = ch
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] = out_byte, tuser = counted,
//                                              tlast = last
//
// One input byte per cycle; the parser classifies it in the cycle it is taken.
// A byte yields zero to three output bytes, sent one per cycle by the serializer while
// m_axis_tready is high, so the input sees back-pressure only when the entry queue (QUEUE_DEPTH) fills.
// The output bytes of an input transfer pass through the entry queue and the serializer's work register.
// rst_n clears parser state, queue pointers and the serializer at once.
module dash_keyword_value_tokenizer
    import dkv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] counted
    output logic       m_axis_tlast
);

    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t pop_entry;
    qstat_t qstat;

    assign s_axis_tready = !qstat.full;

    // Parser
    dkv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .ch         (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    // Entry queue
    dkv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (qstat)
    );

    // Serializer
    dkv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!qstat.empty),
        .q_entry   (pop_entry),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .counted   (m_axis_tuser),
        .last      (m_axis_tlast)
    );

    // Final terminator is an uncounted zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_NUL && !m_axis_tuser)
        else $error("final terminator malformed");

    // Every byte other than the final terminator is counted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("uncounted byte before terminator");

    // Empty entries never enter the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_entry.n != 2'd0)
        else $error("empty entry pushed");

endmodule

// ===== hdl/dkv_front.sv =====
module dkv_front
    import dkv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_ready,
    input  logic [7:0] ch,
    output logic   push,
    output entry_t push_entry
);

    typedef struct packed {
        pstate_t st;
        entry_t  e;
    } step_t;

    localparam pstate_t ST_RESET = '{phase: PH_SEEK, quoted_value: 1'b0, quote_pending: 1'b0};

    pstate_t state_reg;
    pstate_t state_next;
    step_t   step;

    // Append one result byte to the entry
    function automatic step_t put_r(step_t s, logic [7:0] b, logic cnt, logic lst);
        step_t r;
        r = s;
        unique case (s.e.n)
            2'd0: r.e.slot[0] = '{data: b, counted: cnt, last: lst};
            2'd1: r.e.slot[1] = '{data: b, counted: cnt, last: lst};
            2'd2: r.e.slot[2] = '{data: b, counted: cnt, last: lst};
            default: r.e.slot[2] = s.e.slot[2];
        endcase
        if (s.e.n != 2'd3)
        begin
            r.e.n = s.e.n + 2'd1;
        end
        return r;
    endfunction

    // Final terminator, back to reset state
    function automatic step_t finish_r(step_t s);
        step_t r;
        r = put_r(s, CH_NUL, 1'b0, 1'b1);
        r.st = ST_RESET;
        return r;
    endfunction

    // Byte seen while looking for a keyword dash
    function automatic step_t seek_r(step_t s, logic [7:0] c);
        step_t r;
        r = s;
        priority if (c == CH_SPACE)
        begin
            r = s;
        end
        else if (c == CH_DASH)
        begin
            r.st.phase = PH_KEY;
        end
        else if (c == CH_NUL)
        begin
            r = finish_r(s);
        end
        else
        begin
            r = finish_r(s);
            r.st.phase = PH_IGNORE;
        end
        return r;
    endfunction

    // Byte inside a value
    function automatic step_t value_r(step_t s, logic [7:0] c);
        step_t r;
        r = s;
        priority if (c == CH_QUOTE)
        begin
            r.st.quote_pending = 1'b1;
        end
        else if (c == CH_NUL)
        begin
            r = finish_r(put_r(s, CH_NUL, 1'b1, 1'b0));
        end
        else if (c == CH_SPACE && !s.st.quoted_value)
        begin
            r = put_r(s, CH_NUL, 1'b1, 1'b0);
            r.st.phase = PH_SEEK;
        end
        else
        begin
            r = put_r(s, c, 1'b1, 1'b0);
        end
        return r;
    endfunction

    // Byte between a key and its value
    function automatic step_t preval_r(step_t s, logic [7:0] c);
        step_t r;
        r = s;
        priority if (c == CH_SPACE)
        begin
            r = s;
        end
        else if (c == CH_DASH)
        begin
            r = finish_r(s);
            r.st.phase = PH_IGNORE;
        end
        else if (c == CH_QUOTE)
        begin
            r.st.quoted_value = 1'b1;
            r.st.phase = PH_VALSTART;
        end
        else if (c == CH_NUL)
        begin
            r = finish_r(s);
        end
        else
        begin
            r.st.quoted_value = 1'b0;
            r.st.phase = PH_VALUE;
            r = value_r(r, c);
        end
        return r;
    endfunction

    // Classify the current byte against the parser state
    always_comb
    begin
        step_t s;
        s.st = state_reg;
        s.e  = '0;
        step = s;
        unique case (state_reg.phase)
            PH_KEY:
            begin
                priority if (ch == CH_NUL)
                begin
                    step = finish_r(put_r(s, CH_NUL, 1'b1, 1'b0));
                end
                else if (ch == CH_SPACE)
                begin
                    step = put_r(s, CH_NUL, 1'b1, 1'b0);
                    step.st.phase = PH_PREVAL;
                end
                else if (ch >= CH_LC_A && ch <= CH_LC_Z)
                begin
                    step = put_r(s, ch - CASE_OFS, 1'b1, 1'b0);
                end
                else
                begin
                    step = put_r(s, ch, 1'b1, 1'b0);
                end
            end
            PH_PREVAL:
            begin
                step = preval_r(s, ch);
            end
            PH_VALSTART:
            begin
                if (ch == CH_NUL)
                begin
                    step = finish_r(s);
                end
                else
                begin
                    s.st.phase = PH_VALUE;
                    step = value_r(s, ch);
                end
            end
            PH_VALUE:
            begin
                if (state_reg.quote_pending)
                begin
                    s.st.quote_pending = 1'b0;
                    priority if (ch == CH_QUOTE)
                    begin
                        step = put_r(s, CH_QUOTE, 1'b1, 1'b0);
                    end
                    else if (state_reg.quoted_value)
                    begin
                        // closing quote: end the value, then look for a dash
                        step = put_r(s, CH_NUL, 1'b1, 1'b0);
                        step.st = ST_RESET;
                        step = seek_r(step, ch);
                    end
                    else
                    begin
                        step = value_r(put_r(s, CH_QUOTE, 1'b1, 1'b0), ch);
                    end
                end
                else
                begin
                    step = value_r(s, ch);
                end
            end
            PH_IGNORE:
            begin
                if (ch == CH_NUL)
                begin
                    step.st = ST_RESET;
                end
            end
            default:
            begin
                s.st = ST_RESET;
                step = seek_r(s, ch);
            end
        endcase
    end

    // Next state: advance only on a transfer
    always_comb
    begin
        state_next = state_reg;
        if (in_valid && in_ready)
        begin
            state_next = step.st;
        end
    end

    // Outputs: hand the entry to the queue when it holds results
    always_comb
    begin
        push       = in_valid && in_ready && (step.e.n != 2'd0);
        push_entry = step.e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/dkv_queue.sv =====
module dkv_queue
    import dkv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output qstat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/dkv_back.sv =====
module dkv_back
    import dkv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  entry_t     q_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       counted,
    output logic       last
);

    entry_t     work_reg;
    entry_t     work_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       busy_reg;
    logic       busy_next;
    logic       at_end;
    logic       xfer;
    res_t       cur;

    assign xfer   = busy_reg && out_ready;
    assign at_end = (idx_reg == work_reg.n - 2'd1);
    assign pop    = q_valid && (!busy_reg || (xfer && at_end));

    // Pick the slot being shown
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur = work_reg.slot[0];
            2'd1:    cur = work_reg.slot[1];
            default: cur = work_reg.slot[2];
        endcase
    end

    assign out_valid = busy_reg;
    assign out_byte  = cur.data;
    assign counted   = cur.counted;
    assign last      = cur.last;

    // Step through the entry, load the next one as the last slot leaves
    always_comb
    begin
        work_next = work_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (pop)
        begin
            work_next = q_entry;
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (xfer)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

// ===== test/dash_keyword_value_tokenizer_checker.sv =====
`timescale 1ns / 100ps

// Watches both stream channels of the tokenizer, predicts the key/value
// buffer from every input transfer and checks every output transfer.
module dash_keyword_value_tokenizer_checker
    import dkv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tuser,   // [0] counted
    input  logic       m_axis_tlast,
    output int         mismatches,
    output int         bytes_due,
    output int         parsed_bytes
);

    // Expected output bytes, oldest first
    res_t   due_bytes[$];

    // Predicted parser state
    phase_t ph          = PH_SEEK;
    logic   in_quotes   = 1'b0;
    logic   quote_held  = 1'b0;

    int     mismatch_count = 0;
    int     due_count      = 0;
    int     parsed_count   = 0;

    assign mismatches   = mismatch_count;
    assign bytes_due    = due_count;
    assign parsed_bytes = parsed_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic cnt, input logic lst);
        res_t r;
        r.data    = d;
        r.counted = cnt;
        r.last    = lst;
        due_bytes.push_back(r);
    endtask

    // Final terminator; parser goes back to its idle state
    task automatic end_command();
        push_byte(CH_NUL, 1'b0, 1'b1);
        ph         = PH_SEEK;
        in_quotes  = 1'b0;
        quote_held = 1'b0;
    endtask

    // Looking for the dash that opens a keyword
    task automatic seek_char(input logic [7:0] c);
        if (c != CH_SPACE)
        begin
            if (c == CH_DASH)
                ph = PH_KEY;
            else if (c == CH_NUL)
                end_command();
            else
            begin
                end_command();
                ph = PH_IGNORE;
            end
        end
    endtask

    // One byte of a value with no quote held
    task automatic value_char(input logic [7:0] c);
        if (c == CH_QUOTE)
            quote_held = 1'b1;
        else if (c == CH_NUL)
        begin
            push_byte(CH_NUL, 1'b1, 1'b0);
            end_command();
        end
        else if (c == CH_SPACE && !in_quotes)
        begin
            push_byte(CH_NUL, 1'b1, 1'b0);
            ph = PH_SEEK;
        end
        else
            push_byte(c, 1'b1, 1'b0);
    endtask

    task automatic tokenize_char(input logic [7:0] c);
        logic [7:0] folded;
        case (ph)
            PH_KEY:
            begin
                if (c == CH_NUL)
                begin
                    push_byte(CH_NUL, 1'b1, 1'b0);
                    end_command();
                end
                else if (c == CH_SPACE)
                begin
                    push_byte(CH_NUL, 1'b1, 1'b0);
                    ph = PH_PREVAL;
                end
                else
                begin
                    folded = c;
                    if (c >= CH_LC_A && c <= CH_LC_Z)
                        folded = c - CASE_OFS;
                    push_byte(folded, 1'b1, 1'b0);
                end
            end
            PH_PREVAL:
            begin
                // spaces before a value are dropped
                if (c == CH_DASH)
                begin
                    end_command();
                    ph = PH_IGNORE;
                end
                else if (c == CH_QUOTE)
                begin
                    in_quotes = 1'b1;
                    ph        = PH_VALSTART;
                end
                else if (c == CH_NUL)
                    end_command();
                else if (c != CH_SPACE)
                begin
                    in_quotes = 1'b0;
                    ph        = PH_VALUE;
                    value_char(c);
                end
            end
            PH_VALSTART:
            begin
                if (c == CH_NUL)
                    end_command();
                else
                begin
                    ph = PH_VALUE;
                    value_char(c);
                end
            end
            PH_VALUE:
            begin
                if (quote_held)
                begin
                    // look-ahead on a held quote
                    quote_held = 1'b0;
                    if (c == CH_QUOTE)
                        push_byte(CH_QUOTE, 1'b1, 1'b0);
                    else if (in_quotes)
                    begin
                        push_byte(CH_NUL, 1'b1, 1'b0);
                        ph        = PH_SEEK;
                        in_quotes = 1'b0;
                        seek_char(c);
                    end
                    else
                    begin
                        push_byte(CH_QUOTE, 1'b1, 1'b0);
                        value_char(c);
                    end
                end
                else
                    value_char(c);
            end
            PH_IGNORE:
            begin
                if (c == CH_NUL)
                begin
                    ph         = PH_SEEK;
                    in_quotes  = 1'b0;
                    quote_held = 1'b0;
                end
            end
            default:
            begin
                ph         = PH_SEEK;
                in_quotes  = 1'b0;
                quote_held = 1'b0;
                seek_char(c);
            end
        endcase
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            due_bytes.delete();
            ph         = PH_SEEK;
            in_quotes  = 1'b0;
            quote_held = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parsed_count++;
                tokenize_char(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data    = m_axis_tdata;
                got.counted = m_axis_tuser;
                got.last    = m_axis_tlast;
                if (due_bytes.size() == 0)
                    report_mismatch($sformatf("output %02h user %b last %b, none expected",
                                              got.data, got.counted, got.last));
                else
                begin
                    want = due_bytes.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got %02h user %b last %b, expected %02h user %b last %b",
                            got.data, got.counted, got.last,
                            want.data, want.counted, want.last));
                end
            end
        end
        due_count = due_bytes.size();
    end

endmodule

// ===== test/dash_keyword_value_tokenizer_test.sv =====
`timescale 1ns / 100ps

module dash_keyword_value_tokenizer_test
    import dkv_pkg::*;
();

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] ch
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tuser;            // [0] counted
    logic       m_axis_tlast;

    int         mismatches;
    int         bytes_due;
    int         parsed_bytes;

    // Idle-free stretches on each side, and the one long receiver hold-off
    int         tx_run       = 0;
    int         rx_run       = 0;
    bit         hold_request = 1'b0;

    // Bytes of the command being built
    logic [7:0] cmd[$];

    dash_keyword_value_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dash_keyword_value_tokenizer_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .bytes_due     (bytes_due),
        .parsed_bytes  (parsed_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Wait before a transfer: a random gap, or none during an idle-free run
    function automatic int pick_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            run = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_run);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_command();
        foreach (cmd[i])
            send_byte(cmd[i]);
        cmd.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cmd.push_back(s[i]);
    endtask

    // Key byte: mostly around the letter range, sometimes anything but space and zero
    function automatic logic [7:0] rand_key_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) != 0)
            c = 8'($urandom_range(8'h40, 8'h7F));
        else
        begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_SPACE)
                c = 8'hA0;
        end
        return c;
    endfunction

    // Value byte, never zero
    function automatic logic [7:0] rand_value_char(input bit allow_space);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return CH_QUOTE;
        if (pick == 1 && allow_space)
            return CH_SPACE;
        if (pick <= 2)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    // One command of key/value pairs; a broken one is cut short or has a byte replaced
    task automatic build_command(input bit broken);
        int         pairs;
        int         idx;
        logic [7:0] c;
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++)
        begin
            repeat ($urandom_range(0, 2)) cmd.push_back(CH_SPACE);
            cmd.push_back(CH_DASH);
            repeat ($urandom_range(1, 4)) cmd.push_back(rand_key_char());
            repeat ($urandom_range(1, 2)) cmd.push_back(CH_SPACE);
            if ($urandom_range(0, 1))
            begin
                // quoted value, inner quotes doubled
                cmd.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    c = rand_value_char(1'b1);
                    cmd.push_back(c);
                    if (c == CH_QUOTE)
                        cmd.push_back(CH_QUOTE);
                end
                cmd.push_back(CH_QUOTE);
                if ($urandom_range(0, 1))
                    cmd.push_back(CH_SPACE);
            end
            else
            begin
                c = rand_value_char(1'b0);
                if (c == CH_QUOTE || c == CH_DASH)
                    c = "v";
                cmd.push_back(c);
                repeat ($urandom_range(0, 4)) cmd.push_back(rand_value_char(1'b0));
                cmd.push_back(CH_SPACE);
            end
        end
        if (broken)
        begin
            idx = $urandom_range(0, cmd.size() - 1);
            if ($urandom_range(0, 1))
            begin
                while (cmd.size() > idx + 1)
                    void'(cmd.pop_back());
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       cmd[idx] = CH_DASH;
                    1:       cmd[idx] = CH_QUOTE;
                    2:       cmd[idx] = CH_SPACE;
                    default: cmd[idx] = 8'($urandom_range(1, 255));
                endcase
            end
        end
        cmd.push_back(CH_NUL);
    endtask

    // Receiver: random stalls, one long hold-off
    initial
    begin : sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = 300;
            end
            else
                gap = pick_gap(rx_run);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Stimulus and verdict
    initial
    begin : source
        int target;
        int kind;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keyword without a dash, with a high byte in the ignored tail
        add_text("Z");
        cmd.push_back(8'hFF);
        cmd.push_back(CH_NUL);
        send_command();
        // Line ends right after a lower-case key
        add_text("-a");
        cmd.push_back(CH_NUL);
        send_command();
        // Dash where a value should start
        add_text("-k -");
        cmd.push_back(CH_NUL);
        send_command();
        // Line ends after an opening quote
        add_text("-Q \"");
        cmd.push_back(CH_NUL);
        send_command();
        // Lone quote in a plain value, line ends inside the value
        add_text("-v a\"b");
        cmd.push_back(CH_NUL);
        send_command();
        // Doubled quote in a quoted value, closing quote then a non-dash
        add_text("-q \"\"\"x\"z");
        cmd.push_back(CH_NUL);
        send_command();

        // Random commands; the receiver holds off early on so the queue backs up
        hold_request = 1'b1;
        target = 170;
        while (parsed_bytes < target)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
                build_command(1'b0);
            else if (kind < 17)
                build_command(1'b1);
            else
            begin
                repeat ($urandom_range(1, 6)) cmd.push_back(8'($urandom_range(0, 255)));
                cmd.push_back(CH_NUL);
            end
            send_command();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then keep watching for anything unexpected before the verdict
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
